// File: sv/pst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the prefix sum tree engine.
// No dependencies; used by the controller, datapath and top level.
package pst_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 11;
    // Tree position: holds index+1, the effective size and an upward step past it.
    localparam int POS_W  = 12;

    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_PREFIX = 2'd1;
    localparam logic [1:0] FN_RANGE  = 2'd2;
    localparam logic [1:0] FN_RSVD   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RD,
        ST_USE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;   // write zero at the sweep address, advance the sweep
        logic load;    // capture the input beat and the effective size
        logic start;   // set up the first walk
        logic read;    // read the entry at the current position
        logic step;    // fold the read entry in, move to the next position
        logic second;  // set up the low-end walk of a range query
        logic emit;    // load the result register
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic err;
        logic walk_more;
        logic second_pending;
        logic out_free;
    } stat_t;

endpackage

// File: sv/pst_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the prefix sum tree engine.
// Depends on pst_pkg for the state, command and status types.
module pst_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pst_pkg::stat_t  stat,
    output pst_pkg::cmd_t   cmd
);

    pst_pkg::state_t state_reg;
    pst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pst_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            pst_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = pst_pkg::ST_IDLE;
                end
            end
            pst_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = pst_pkg::ST_CHECK;
                end
            end
            pst_pkg::ST_CHECK:
            begin
                if (stat.err)
                begin
                    state_next = pst_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = pst_pkg::ST_RD;
                end
            end
            pst_pkg::ST_RD:
            begin
                priority if (stat.walk_more)
                begin
                    cmd.read   = 1'b1;
                    state_next = pst_pkg::ST_USE;
                end
                else if (stat.second_pending)
                begin
                    cmd.second = 1'b1;
                end
                else
                begin
                    state_next = pst_pkg::ST_FINISH;
                end
            end
            pst_pkg::ST_USE:
            begin
                cmd.step   = 1'b1;
                state_next = pst_pkg::ST_RD;
            end
            pst_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = pst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pst_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: sv/pst_dp.sv
`timescale 1ns / 1ps
// Datapath of the prefix sum tree engine: partial sum memory, walk position,
// accumulators and result register. Depends on pst_pkg.
module pst_dp
#(
    parameter int DEPTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic        [pst_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic        [1:0]                   func,
    input  logic        [pst_pkg::IDX_W-1:0]    index,
    input  logic        [pst_pkg::IDX_W-1:0]    upper_index,
    input  logic signed [pst_pkg::DATA_W-1:0]   delta,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pst_pkg::DATA_W-1:0]   sum,
    output logic                                status,
    input  pst_pkg::cmd_t                       cmd,
    output pst_pkg::stat_t                      stat
);

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int XW = (AW > pst_pkg::POS_W) ? AW : pst_pkg::POS_W;
    localparam int PW = pst_pkg::POS_W;
    localparam int DW = pst_pkg::DATA_W;
    localparam int IW = pst_pkg::IDX_W;

    logic [DW-1:0]  psum_reg [DEPTH];
    logic [DW-1:0]  rdata_reg;

    logic [pst_pkg::SIZE_W-1:0] active_reg, active_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [1:0]     func_reg, func_next;
    logic [IW-1:0]  lo_reg, lo_next;
    logic [IW-1:0]  hi_reg, hi_next;
    logic [DW-1:0]  delta_reg, delta_next;
    logic [PW-1:0]  size_reg, size_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [DW-1:0]  acc_reg, acc_next;
    logic [DW-1:0]  hold_reg, hold_next;
    logic           phase_reg, phase_next;
    logic           out_valid_reg, out_valid_next;
    logic [DW-1:0]  sum_reg, sum_next;
    logic           status_reg, status_next;

    logic [PW-1:0]  size_cap;
    logic [PW-1:0]  low_bit;
    logic [PW-1:0]  pos_m1;
    logic [XW-1:0]  addr_x;
    logic [AW-1:0]  addr;
    logic           is_add;
    logic           is_range;
    logic           err;
    logic           out_free;
    logic [DW-1:0]  result;

    assign size_cap = (32'(active_reg) > 32'(DEPTH)) ? PW'(DEPTH) : PW'(active_reg);
    assign low_bit  = pos_reg & (~pos_reg + PW'(1));
    assign pos_m1   = pos_reg - PW'(1);
    assign addr_x   = XW'(pos_m1);
    assign addr     = addr_x[AW-1:0];
    assign is_add   = (func_reg == pst_pkg::FN_ADD);
    assign is_range = (func_reg == pst_pkg::FN_RANGE);
    assign err      = (func_reg == pst_pkg::FN_RSVD)
                   || (PW'(lo_reg) >= size_reg)
                   || (is_range && (PW'(hi_reg) >= size_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign result   = (err || is_add) ? '0 : (is_range ? (hold_reg - acc_reg) : acc_reg);

    assign stat.clear_last     = (clr_reg == AW'(DEPTH - 1));
    assign stat.err            = err;
    assign stat.walk_more      = is_add ? ((pos_reg != '0) && (pos_reg <= size_reg))
                                        : (pos_reg != '0);
    assign stat.second_pending = is_range && !phase_reg;
    assign stat.out_free       = out_free;

    assign out_valid = out_valid_reg;
    assign sum       = $signed(sum_reg);
    assign status    = status_reg;

    always_comb
    begin
        active_next    = cfg_wen ? cfg_wdata : active_reg;
        clr_next       = cmd.clear ? (clr_reg + AW'(1)) : clr_reg;
        func_next      = cmd.load ? func : func_reg;
        lo_next        = cmd.load ? index : lo_reg;
        hi_next        = cmd.load ? upper_index : hi_reg;
        delta_next     = cmd.load ? $unsigned(delta) : delta_reg;
        size_next      = cmd.load ? size_cap : size_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        phase_next     = phase_reg;
        priority if (cmd.start)
        begin
            pos_next   = PW'(is_range ? hi_reg : lo_reg) + PW'(1);
            acc_next   = '0;
            phase_next = 1'b0;
        end
        else if (cmd.second)
        begin
            hold_next  = acc_reg;
            acc_next   = '0;
            pos_next   = PW'(lo_reg);
            phase_next = 1'b1;
        end
        else if (cmd.step)
        begin
            if (is_add)
            begin
                pos_next = pos_reg + low_bit;
            end
            else
            begin
                pos_next = pos_reg - low_bit;
                acc_next = acc_reg + rdata_reg;
            end
        end
        else
        begin
            pos_next = pos_reg;
        end
        out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && out_stall);
        sum_next       = cmd.emit ? result : sum_reg;
        status_next    = cmd.emit ? err : status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        delta_reg  <= delta_next;
        size_reg   <= size_next;
        pos_reg    <= pos_next;
        acc_reg    <= acc_next;
        hold_reg   <= hold_next;
        phase_reg  <= phase_next;
        sum_reg    <= sum_next;
        status_reg <= status_next;
    end

    // Single write port shared by the clearing sweep and update write-back.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            psum_reg[clr_reg] <= '0;
        end
        else if (cmd.step && is_add)
        begin
            psum_reg[addr] <= rdata_reg + delta_reg;
        end
        if (cmd.read)
        begin
            rdata_reg <= psum_reg[addr];
        end
    end

endmodule

// File: sv/prefix_sum_tree_engine.sv
`timescale 1ns / 1ps
// Top level of the prefix sum tree engine: binary indexed tree over a memory
// of 32-bit partial sums. Instantiates pst_ctrl and pst_dp; uses pst_pkg.
//
// The block holds DEPTH signed 32-bit partial sums that encode an array of
// elements as a binary indexed tree. Each input beat carries one operation:
// add delta at index (func 0), prefix sum of elements 0..index (func 1), or
// the sum of elements index..upper_index (func 2, computed as the difference
// of two prefixes, so a reversed range gives the wrapped difference). Every
// beat yields exactly one result beat; sums wrap modulo 2^32. An update
// returns sum 0, status 0. An index at or beyond the effective size
// (active_size, capped at DEPTH) or the reserved func code gives sum 0 and
// status 1, and leaves the memory untouched. Items are handled one at a time.
// Each tree step is a registered read on the single memory port, then an
// accumulate or a write back. The number of entries walked is at most
// log2(DEPTH)+1 for an update, log2(DEPTH) for a prefix query and twice that
// for a range query. An error item skips the walk. The result register
// frees the input side, so a new beat is taken while the previous result
// still waits. After reset the memory is swept to zero, one entry per cycle;
// in_stall stays high during the sweep, while active_size writes are taken
// as ever. Write active_size only while the block is idle.
module prefix_sum_tree_engine
#(
    parameter int DEPTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic        [pst_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic        [1:0]                   func,
    input  logic        [pst_pkg::IDX_W-1:0]    index,
    input  logic        [pst_pkg::IDX_W-1:0]    upper_index,
    input  logic signed [pst_pkg::DATA_W-1:0]   delta,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pst_pkg::DATA_W-1:0]   sum,
    output logic                                status
);

    // Command and status bundles between sequencer and datapath.
    pst_pkg::cmd_t  cmd;
    pst_pkg::stat_t stat;

    // Sequencer: clearing sweep, accept, walk loop, result hand-off.
    pst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: memory, position arithmetic, accumulators, result register.
    pst_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .func        (func),
        .index       (index),
        .upper_index (upper_index),
        .delta       (delta),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sum         (sum),
        .status      (status),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// File: sv/pst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the prefix sum tree engine, bound to the top level.
// Depends on prefix_sum_tree_engine port names only.
module pst_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [31:0]  sum,
    input  logic                status
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sum) && $stable(status))
        else $error("result beat changed while stalled");

    // An error result always carries a zero sum.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> sum == 32'sd0)
        else $error("error result with non-zero sum");

    // One item at a time: the cycle after an accept stalls the input.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // No result can appear in the cycle right after an accept.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind prefix_sum_tree_engine pst_checker u_pst_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum       (sum),
    .status    (status)
);
